// ----- hw/rtl/sdtp_pkg.sv -----
// Shared types and constants for the service description table section parser.
// No dependencies; imported by sdt_section_parser_unit.
package sdtp_pkg;

  // Kind of record delivered on the result channel.
  typedef enum logic [2:0] {
    KIND_HEADER     = 3'd0,
    KIND_SERVICE    = 3'd1,
    KIND_DESCRIPTOR = 3'd2,
    KIND_CRC        = 3'd3,
    KIND_REJECT     = 3'd4
  } record_kind_e;

  // Shortest legal section length: fixed header plus CRC.
  localparam logic [11:0] MinSectionLen = 12'd12;
  // Bytes of the section length that lie outside the service loop.
  localparam logic [11:0] LoopOverhead  = 12'd12;

  // Header byte positions counted from the table id byte.
  localparam logic [3:0] PosSecLenHi = 4'd1;
  localparam logic [3:0] PosSecLenLo = 4'd2;
  localparam logic [3:0] PosHoldLast = 4'd8;
  localparam logic [3:0] PosHeadOut  = 4'd9;
  // Number of CRC bytes that close a section.
  localparam logic [3:0] CrcBytes    = 4'd4;

endpackage

// ----- hw/rtl/sdt_section_parser_unit.sv -----
// Service description table section parser: one section byte per beat in,
// header, service, descriptor, CRC and reject records out. Depends on sdtp_pkg.
// A record is registered in the result register when its byte leaves the byte register.
// Throughput: one byte per cycle; all parsing is combinational between the
// byte register and the result register, and a byte waits in the byte register
// only behind an untaken record. Reset clears the phase, counters and valid flags.
module sdt_section_parser_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [7:0]                data_byte_i,
  input  logic                      section_start_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output sdtp_pkg::record_kind_e    record_kind_o,
  output logic [7:0]                tbl_ident_o,
  output logic [11:0]               length_value_o,
  output logic [15:0]               id_value_o,
  output logic [4:0]                version_number_o,
  output logic                      current_next_o,
  output logic [7:0]                sec_number_o,
  output logic [7:0]                last_sec_number_o,
  output logic [12:0]               network_id_o,
  output logic [5:0]                service_flags_o,
  output logic [31:0]               crc_value_o
);
  import sdtp_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_HEAD,
    PH_LOOP,
    PH_CRC
  } phase_e;

  // Position inside a service entry or its descriptor loop.
  typedef enum logic [2:0] {
    ENT_SVC_ID_HI,
    ENT_SVC_ID_LO,
    ENT_EIT_FLAGS,
    ENT_LOOP_HI,
    ENT_LOOP_LO,
    ENT_TAG,
    ENT_DLEN,
    ENT_BODY
  } entry_e;

  // Input register.
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_start_q;

  // Parser state.
  phase_e      phase_q, phase_d;
  logic [3:0]  byte_pos_q, byte_pos_d;
  logic [11:0] sec_len_q, sec_len_d;
  logic [47:0] hdr_q, hdr_d;
  entry_e      entry_q, entry_d;
  logic [15:0] svc_id_q, svc_id_d;
  logic [5:0]  svc_flags_q, svc_flags_d;
  logic [11:0] loop_rem_q, loop_rem_d;
  logic [7:0]  dskip_q, dskip_d;
  logic [31:0] crc_q, crc_d;
  logic [7:0]  tbl_ident_q, tbl_ident_d;
  logic [11:0] dloop_q, dloop_d;

  // Result of the current byte.
  logic         res_valid;
  record_kind_e res_kind;
  logic [11:0]  res_length;
  logic [15:0]  res_id;
  logic [4:0]   res_version;
  logic         res_cur_next;
  logic [7:0]   res_sec_num;
  logic [7:0]   res_last_sec;
  logic [12:0]  res_network;
  logic [5:0]   res_flags;
  logic [31:0]  res_crc;

  logic         out_valid_q;
  logic         advance;
  logic [3:0]   pos_inc;
  logic [11:0]  len_new;
  logic [11:0]  loop_len;
  logic [11:0]  dloop_dec;
  logic [7:0]   dskip_dec;

  // Handshake: the byte register moves on whenever the result register is free.
  assign advance     = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !in_valid_q || advance;
  assign out_valid_o = out_valid_q;

  assign pos_inc   = byte_pos_q + 4'd1;
  assign len_new   = {hdr_q[3:0], in_byte_q};
  assign loop_len  = sec_len_q - LoopOverhead;
  assign dloop_dec = dloop_q - 12'd1;
  assign dskip_dec = dskip_q - 8'd1;

  // Next state and result for the byte held in the input register.
  always_comb begin
    phase_d      = phase_q;
    byte_pos_d   = byte_pos_q;
    sec_len_d    = sec_len_q;
    hdr_d        = hdr_q;
    entry_d      = entry_q;
    svc_id_d     = svc_id_q;
    svc_flags_d  = svc_flags_q;
    loop_rem_d   = loop_rem_q;
    dskip_d      = dskip_q;
    crc_d        = crc_q;
    tbl_ident_d  = tbl_ident_q;
    dloop_d      = dloop_q;
    res_valid    = 1'b0;
    res_kind     = KIND_HEADER;
    res_length   = '0;
    res_id       = '0;
    res_version  = '0;
    res_cur_next = 1'b0;
    res_sec_num  = '0;
    res_last_sec = '0;
    res_network  = '0;
    res_flags    = '0;
    res_crc      = '0;

    if (in_start_q) begin
      // A start byte restarts parsing from any phase.
      phase_d     = PH_HEAD;
      byte_pos_d  = '0;
      tbl_ident_d = in_byte_q;
      hdr_d       = '0;
      crc_d       = '0;
      entry_d     = ENT_SVC_ID_HI;
    end else begin
      unique case (phase_q)
        PH_HEAD: begin
          byte_pos_d = pos_inc;
          if (pos_inc == PosSecLenHi) begin
            hdr_d = {40'd0, in_byte_q};
          end else if (pos_inc == PosSecLenLo) begin
            sec_len_d = len_new;
            hdr_d     = '0;
            if (!hdr_q[7] || (len_new < MinSectionLen)) begin
              res_valid  = 1'b1;
              res_kind   = KIND_REJECT;
              res_length = len_new;
              phase_d    = PH_IDLE;
            end
          end else if (pos_inc <= PosHoldLast) begin
            hdr_d = {hdr_q[39:0], in_byte_q};
          end else if (pos_inc == PosHeadOut) begin
            res_valid    = 1'b1;
            res_kind     = KIND_HEADER;
            res_length   = sec_len_q;
            res_id       = hdr_q[47:32];
            res_version  = hdr_q[29:25];
            res_cur_next = hdr_q[24];
            res_sec_num  = hdr_q[23:16];
            res_last_sec = hdr_q[15:8];
            res_network  = {hdr_q[4:0], in_byte_q};
          end else begin
            // Reserved byte after the network id: set up the service loop.
            loop_rem_d = loop_len;
            entry_d    = ENT_SVC_ID_HI;
            byte_pos_d = '0;
            crc_d      = '0;
            phase_d    = (loop_len == 12'd0) ? PH_CRC : PH_LOOP;
          end
        end

        PH_LOOP: begin
          unique case (entry_q)
            ENT_SVC_ID_HI: begin
              svc_id_d    = {in_byte_q, 8'd0};
              svc_flags_d = '0;
              entry_d     = ENT_SVC_ID_LO;
            end
            ENT_SVC_ID_LO: begin
              svc_id_d = {svc_id_q[15:8], in_byte_q};
              entry_d  = ENT_EIT_FLAGS;
            end
            ENT_EIT_FLAGS: begin
              svc_flags_d = {svc_flags_q[5:2], in_byte_q[1:0]};
              entry_d     = ENT_LOOP_HI;
            end
            ENT_LOOP_HI: begin
              svc_flags_d = {in_byte_q[4], in_byte_q[7:5], svc_flags_q[1:0]};
              dloop_d     = {in_byte_q[3:0], 8'd0};
              entry_d     = ENT_LOOP_LO;
            end
            ENT_LOOP_LO: begin
              dloop_d    = {dloop_q[11:8], in_byte_q};
              res_valid  = 1'b1;
              res_kind   = KIND_SERVICE;
              res_length = {dloop_q[11:8], in_byte_q};
              res_id     = svc_id_q;
              res_flags  = svc_flags_q;
              entry_d    = ({dloop_q[11:8], in_byte_q} != 12'd0) ? ENT_TAG : ENT_SVC_ID_HI;
            end
            ENT_TAG: begin
              dskip_d = in_byte_q;
              dloop_d = dloop_dec;
              entry_d = (dloop_dec != 12'd0) ? ENT_DLEN : ENT_SVC_ID_HI;
            end
            ENT_DLEN: begin
              dloop_d    = dloop_dec;
              res_valid  = 1'b1;
              res_kind   = KIND_DESCRIPTOR;
              res_length = {4'd0, in_byte_q};
              res_id     = {8'd0, dskip_q};
              dskip_d    = in_byte_q;
              if (dloop_dec == 12'd0) begin
                entry_d = ENT_SVC_ID_HI;
              end else begin
                entry_d = (in_byte_q != 8'd0) ? ENT_BODY : ENT_TAG;
              end
            end
            ENT_BODY: begin
              // Descriptor bodies are skipped, bounded by the descriptor loop.
              dloop_d = dloop_dec;
              dskip_d = dskip_dec;
              if (dloop_dec == 12'd0) begin
                entry_d = ENT_SVC_ID_HI;
              end else if (dskip_dec == 8'd0) begin
                entry_d = ENT_TAG;
              end
            end
            default: entry_d = ENT_SVC_ID_HI;
          endcase
          loop_rem_d = loop_rem_q - 12'd1;
          if (loop_rem_q == 12'd1) begin
            phase_d    = PH_CRC;
            byte_pos_d = '0;
            crc_d      = '0;
          end
        end

        PH_CRC: begin
          crc_d      = {crc_q[23:0], in_byte_q};
          byte_pos_d = pos_inc;
          if (pos_inc >= CrcBytes) begin
            res_valid = 1'b1;
            res_kind  = KIND_CRC;
            res_crc   = {crc_q[23:0], in_byte_q};
            phase_d   = PH_IDLE;
          end
        end

        default: ;
      endcase
    end
  end

  // Input register, parser state and result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      phase_q     <= PH_IDLE;
      byte_pos_q  <= '0;
      entry_q     <= ENT_SVC_ID_HI;
      loop_rem_q  <= '0;
      dloop_q     <= '0;
      dskip_q     <= '0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      out_valid_q <= (out_valid_q && !out_ready_i) || (advance && res_valid);
      if (advance) begin
        phase_q    <= phase_d;
        byte_pos_q <= byte_pos_d;
        entry_q    <= entry_d;
        loop_rem_q <= loop_rem_d;
        dloop_q    <= dloop_d;
        dskip_q    <= dskip_d;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_byte_q  <= data_byte_i;
      in_start_q <= section_start_i;
    end
    if (advance) begin
      sec_len_q   <= sec_len_d;
      hdr_q       <= hdr_d;
      svc_id_q    <= svc_id_d;
      svc_flags_q <= svc_flags_d;
      crc_q       <= crc_d;
      tbl_ident_q <= tbl_ident_d;
    end
    if (advance && res_valid) begin
      record_kind_o     <= res_kind;
      tbl_ident_o       <= tbl_ident_q;
      length_value_o    <= res_length;
      id_value_o        <= res_id;
      version_number_o  <= res_version;
      current_next_o    <= res_cur_next;
      sec_number_o      <= res_sec_num;
      last_sec_number_o <= res_last_sec;
      network_id_o      <= res_network;
      service_flags_o   <= res_flags;
      crc_value_o       <= res_crc;
    end
  end

`ifndef SYNTH
  // The service loop phase is left as soon as its byte budget is spent.
  a_loop_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_LOOP |-> loop_rem_q != 12'd0)
    else $error("service loop phase with no bytes left");

  // The CRC phase ends on its fourth byte.
  a_crc_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_CRC |-> byte_pos_q < CrcBytes)
    else $error("CRC byte counter overran");

  // The header phase never runs past the reserved byte.
  a_head_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_HEAD |-> byte_pos_q <= PosHeadOut)
    else $error("header byte counter overran");

  // A start byte restarts the header phase at position zero.
  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && in_start_q |=> phase_q == PH_HEAD && byte_pos_q == 4'd0)
    else $error("start byte did not restart the header");
`endif

endmodule

// ----- dv/sdt_section_parser_unit_tb.sv -----
// Testbench for sdt_section_parser_unit: directed and random section byte streams,
// with records checked against an in-bench parser model. Depends on sdtp_pkg and
// the sdt_section_parser_unit RTL only.
module sdt_section_parser_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sdtp_pkg::*;

  localparam int ShortestSection = 12;
  localparam int FixedLoopBytes  = 12;
  localparam int CrcByteCount    = 4;
  localparam int LenHiPos        = 1;
  localparam int LenLoPos        = 2;
  localparam int HoldLastPos     = 8;
  localparam int HeaderRecPos    = 9;
  localparam int ItemTarget      = 1150;
  localparam int MaxWait         = 16;
  localparam int ReportMax       = 10;
  localparam int DrainCycles     = 20;
  localparam int CycleLimit      = 500000;

  // One record as seen on the result channel.
  typedef struct packed {
    record_kind_e kind;
    logic [7:0]   tid;
    logic [11:0]  length;
    logic [15:0]  ident;
    logic [4:0]   version;
    logic         cur_next;
    logic [7:0]   sec_num;
    logic [7:0]   last_sec;
    logic [12:0]  net_id;
    logic [5:0]   flags;
    logic [31:0]  crc;
  } sdt_record_t;

  typedef enum logic [1:0] {PH_IDLE, PH_HEAD, PH_LOOP, PH_CRC} parse_phase_e;

  // Where the parser stands inside a service entry.
  typedef enum logic [2:0] {
    ENT_SID_HI, ENT_SID_LO, ENT_EIT, ENT_LOOP_HI, ENT_LOOP_LO, ENT_TAG, ENT_DLEN, ENT_BODY
  } entry_step_e;

  logic         clk_i;
  logic         rst_ni;
  logic         in_valid_i;
  logic         in_ready_o;
  logic [7:0]   data_byte_i;
  logic         section_start_i;
  logic         out_valid_o;
  logic         out_ready_i;
  record_kind_e record_kind_o;
  logic [7:0]   tbl_ident_o;
  logic [11:0]  length_value_o;
  logic [15:0]  id_value_o;
  logic [4:0]   version_number_o;
  logic         current_next_o;
  logic [7:0]   sec_number_o;
  logic [7:0]   last_sec_number_o;
  logic [12:0]  network_id_o;
  logic [5:0]   service_flags_o;
  logic [31:0]  crc_value_o;

  sdt_section_parser_unit dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .data_byte_i       (data_byte_i),
    .section_start_i   (section_start_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .record_kind_o     (record_kind_o),
    .tbl_ident_o       (tbl_ident_o),
    .length_value_o    (length_value_o),
    .id_value_o        (id_value_o),
    .version_number_o  (version_number_o),
    .current_next_o    (current_next_o),
    .sec_number_o      (sec_number_o),
    .last_sec_number_o (last_sec_number_o),
    .network_id_o      (network_id_o),
    .service_flags_o   (service_flags_o),
    .crc_value_o       (crc_value_o)
  );

  // Parser model state.
  parse_phase_e phase_q    = PH_IDLE;
  entry_step_e  entry_step = ENT_SID_HI;
  logic [11:0]  byte_pos   = '0;
  logic [11:0]  sec_len    = '0;
  logic [11:0]  loop_left  = '0;
  logic [11:0]  dloop_left = '0;
  logic [47:0]  hdr_hold   = '0;
  logic [23:0]  svc_hold   = '0;
  logic [7:0]   desc_skip  = '0;
  logic [31:0]  crc_sr     = '0;
  logic [7:0]   cur_table  = '0;

  sdt_record_t  expected_records[$];
  logic [7:0]   section_bytes[$];

  int unsigned  fail_count      = 0;
  int unsigned  bytes_sent      = 0;
  int unsigned  bytes_parsed    = 0;
  int unsigned  records_checked = 0;
  int unsigned  cycle_count     = 0;
  int unsigned  kind_seen[5]    = '{0, 0, 0, 0, 0};
  // Idle styles: 0 never waits, 1 uniform waits, 2 mostly back to back.
  int           src_mode        = 1;
  int           sink_mode       = 1;

  // Clock, 10 ns period.
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic int draw_wait(input int mode);
    case (mode)
      0: return 0;
      1: return $urandom_range(0, MaxWait);
      default: return ($urandom_range(0, 7) == 0) ? $urandom_range(0, MaxWait) : 0;
    endcase
  endfunction

  function automatic string fmt_record(input sdt_record_t r);
    return $sformatf({"kind=%0d tid=%02h len=%03h id=%04h ver=%0d cn=%0d sec=%02h ",
                      "last=%02h nid=%04h flags=%02h crc=%08h"},
                     r.kind, r.tid, r.length, r.ident, r.version, r.cur_next,
                     r.sec_num, r.last_sec, r.net_id, r.flags, r.crc);
  endfunction

  // Advance the parser model by one accepted byte and queue any record it yields.
  function automatic void parse_section_byte(input logic [7:0] b, input logic start);
    sdt_record_t rec;
    logic        emit;
    rec  = '0;
    emit = 1'b0;
    if (start) begin
      phase_q    = PH_HEAD;
      byte_pos   = '0;
      cur_table  = b;
      hdr_hold   = '0;
      crc_sr     = '0;
      entry_step = ENT_SID_HI;
      return;
    end
    rec.tid = cur_table;
    case (phase_q)
      PH_HEAD: begin
        byte_pos = byte_pos + 12'd1;
        if (byte_pos == LenHiPos) begin
          hdr_hold = {40'd0, b};
        end else if (byte_pos == LenLoPos) begin
          sec_len = {hdr_hold[3:0], b};
          // Syntax indicator clear or a section too short to hold header and CRC.
          if (!hdr_hold[7] || sec_len < ShortestSection) begin
            rec.kind   = KIND_REJECT;
            rec.length = sec_len;
            emit       = 1'b1;
            phase_q    = PH_IDLE;
          end
          hdr_hold = '0;
        end else if (byte_pos <= HoldLastPos) begin
          hdr_hold = {hdr_hold[39:0], b};
        end else if (byte_pos == HeaderRecPos) begin
          rec.kind     = KIND_HEADER;
          rec.length   = sec_len;
          rec.ident    = hdr_hold[47:32];
          rec.version  = hdr_hold[29:25];
          rec.cur_next = hdr_hold[24];
          rec.sec_num  = hdr_hold[23:16];
          rec.last_sec = hdr_hold[15:8];
          rec.net_id   = {hdr_hold[4:0], b};
          emit         = 1'b1;
        end else begin
          // Reserved byte: the service loop, or the CRC if the loop is empty, starts with the next byte.
          loop_left  = sec_len - 12'(FixedLoopBytes);
          entry_step = ENT_SID_HI;
          byte_pos   = '0;
          crc_sr     = '0;
          phase_q    = (loop_left == 12'd0) ? PH_CRC : PH_LOOP;
        end
      end
      PH_LOOP: begin
        case (entry_step)
          ENT_SID_HI: begin
            svc_hold   = {b, 16'd0};
            entry_step = ENT_SID_LO;
          end
          ENT_SID_LO: begin
            svc_hold[15:8] = b;
            entry_step     = ENT_EIT;
          end
          ENT_EIT: begin
            svc_hold[1:0] = b[1:0];
            entry_step    = ENT_LOOP_HI;
          end
          ENT_LOOP_HI: begin
            svc_hold[5:2] = {b[4], b[7:5]};
            dloop_left    = {b[3:0], 8'd0};
            entry_step    = ENT_LOOP_LO;
          end
          ENT_LOOP_LO: begin
            dloop_left[7:0] = b;
            rec.kind        = KIND_SERVICE;
            rec.length      = dloop_left;
            rec.ident       = svc_hold[23:8];
            rec.flags       = svc_hold[5:0];
            emit            = 1'b1;
            entry_step      = (dloop_left != 12'd0) ? ENT_TAG : ENT_SID_HI;
          end
          ENT_TAG: begin
            desc_skip  = b;
            dloop_left = dloop_left - 12'd1;
            entry_step = (dloop_left != 12'd0) ? ENT_DLEN : ENT_SID_HI;
          end
          ENT_DLEN: begin
            dloop_left = dloop_left - 12'd1;
            rec.kind   = KIND_DESCRIPTOR;
            rec.length = {4'd0, b};
            rec.ident  = {8'd0, desc_skip};
            emit       = 1'b1;
            desc_skip  = b;
            if (dloop_left == 12'd0) entry_step = ENT_SID_HI;
            else entry_step = (b != 8'd0) ? ENT_BODY : ENT_TAG;
          end
          default: begin
            dloop_left = dloop_left - 12'd1;
            desc_skip  = desc_skip - 8'd1;
            if (dloop_left == 12'd0) entry_step = ENT_SID_HI;
            else if (desc_skip == 8'd0) entry_step = ENT_TAG;
          end
        endcase
        // The loop end forces the CRC phase, whatever the entry state.
        loop_left = loop_left - 12'd1;
        if (loop_left == 12'd0) begin
          phase_q  = PH_CRC;
          byte_pos = '0;
          crc_sr   = '0;
        end
      end
      PH_CRC: begin
        crc_sr   = {crc_sr[23:0], b};
        byte_pos = byte_pos + 12'd1;
        if (byte_pos >= CrcByteCount) begin
          rec.kind = KIND_CRC;
          rec.crc  = crc_sr;
          emit     = 1'b1;
          phase_q  = PH_IDLE;
        end
      end
      default: ;
    endcase
    if (emit) expected_records = {expected_records, rec};
  endfunction

  // Input and output beats: feed the model and check each record taken.
  always @(posedge clk_i) begin : monitor_proc
    sdt_record_t got;
    sdt_record_t want;
    string       diffs;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        bytes_sent++;
        if (section_start_i || phase_q != PH_IDLE) bytes_parsed++;
        parse_section_byte(data_byte_i, section_start_i);
      end
      if (out_valid_o && out_ready_i) begin
        got.kind     = record_kind_o;
        got.tid      = tbl_ident_o;
        got.length   = length_value_o;
        got.ident    = id_value_o;
        got.version  = version_number_o;
        got.cur_next = current_next_o;
        got.sec_num  = sec_number_o;
        got.last_sec = last_sec_number_o;
        got.net_id   = network_id_o;
        got.flags    = service_flags_o;
        got.crc      = crc_value_o;
        records_checked++;
        if (expected_records.size() == 0) begin
          fail_count++;
          if (fail_count <= ReportMax) $display("Unexpected record: %s", fmt_record(got));
        end else begin
          want  = expected_records.pop_front();
          diffs = "";
          if (got.kind !== want.kind) diffs = {diffs, " kind"};
          if (got.tid !== want.tid) diffs = {diffs, " tbl_ident"};
          if (got.length !== want.length) diffs = {diffs, " length"};
          if (got.ident !== want.ident) diffs = {diffs, " id"};
          if (got.version !== want.version) diffs = {diffs, " version"};
          if (got.cur_next !== want.cur_next) diffs = {diffs, " current_next"};
          if (got.sec_num !== want.sec_num) diffs = {diffs, " sec_number"};
          if (got.last_sec !== want.last_sec) diffs = {diffs, " last_sec_number"};
          if (got.net_id !== want.net_id) diffs = {diffs, " network_id"};
          if (got.flags !== want.flags) diffs = {diffs, " flags"};
          if (got.crc !== want.crc) diffs = {diffs, " crc"};
          if (diffs != "") begin
            fail_count++;
            if (fail_count <= ReportMax) begin
              $display("Record mismatch in%s", diffs);
              $display("  expected %s", fmt_record(want));
              $display("  actual   %s", fmt_record(got));
            end
          end
          kind_seen[want.kind]++;
        end
      end
    end
  end

  // Result side: stall a random number of cycles before taking each record.
  initial begin : sink_proc
    int stall;
    forever begin
      stall = draw_wait(sink_mode);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // Drive one byte beat after a random gap and hold it until it is taken.
  task automatic send_beat(input logic [7:0] b, input logic start);
    int gap;
    gap = draw_wait(src_mode);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    data_byte_i     <= b;
    section_start_i <= start;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Send the prepared byte list, flagging its first byte as the table id.
  task automatic send_section();
    foreach (section_bytes[i]) send_beat(section_bytes[i], i == 0);
  endtask

  // Build a well-formed section with random content into section_bytes.
  function automatic void build_section(input int services, input int descs_max,
                                        input int body_max);
    logic [7:0]  loop_bytes[$];
    logic [7:0]  descs[$];
    logic [11:0] len;
    int          nd;
    int          blen;
    loop_bytes = {};
    for (int s = 0; s < services; s++) begin
      descs = {};
      nd    = $urandom_range(0, descs_max);
      for (int d = 0; d < nd; d++) begin
        blen  = $urandom_range(0, body_max);
        descs = {descs, 8'($urandom)};
        descs = {descs, 8'(blen)};
        repeat (blen) descs = {descs, 8'($urandom)};
      end
      // Service id, EIT flags, then status nibble and descriptor loop length.
      repeat (3) loop_bytes = {loop_bytes, 8'($urandom)};
      loop_bytes = {loop_bytes, {4'($urandom), 4'(descs.size() >> 8)}};
      loop_bytes = {loop_bytes, 8'(descs.size())};
      foreach (descs[i]) loop_bytes = {loop_bytes, descs[i]};
    end
    len = 12'(FixedLoopBytes + loop_bytes.size());
    section_bytes = {};
    section_bytes = {section_bytes, 8'($urandom)};
    section_bytes = {section_bytes, {1'b1, 3'($urandom), len[11:8]}};
    section_bytes = {section_bytes, len[7:0]};
    repeat (8) section_bytes = {section_bytes, 8'($urandom)};
    foreach (loop_bytes[i]) section_bytes = {section_bytes, loop_bytes[i]};
    repeat (CrcByteCount) section_bytes = {section_bytes, 8'($urandom)};
  endfunction

  // Stray bytes while idle, then three sections that are rejected.
  task automatic test_reject_and_idle();
    send_beat(8'h00, 1'b0);
    send_beat(8'hFF, 1'b0);
    section_bytes = '{8'h42, 8'h0F, 8'hFF};
    send_section();
    section_bytes = '{8'hFF, 8'hF0, 8'h0B};
    send_section();
    section_bytes = '{8'h00, 8'h80, 8'h00};
    send_section();
    send_beat(8'h5A, 1'b0);
  endtask

  // All-ones header with the longest section length, cut short by a new start in
  // the service loop; then a second start arrives inside the header.
  task automatic test_header_extremes();
    section_bytes = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                      8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    send_section();
    section_bytes = '{8'h4A, 8'h80};
    send_section();
  endtask

  // Shortest legal section: all-zero header, no services, straight to the CRC.
  task automatic test_empty_service_loop();
    section_bytes = '{8'h42, 8'h80, 8'h0C, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                      8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    send_section();
  endtask

  // Service loop corner cases in one section.
  task automatic test_service_loop_cases();
    section_bytes = '{
      8'h42, 8'hB0, 8'h2D, 8'h12, 8'h34, 8'hC3, 8'h00, 8'hFF, 8'hFF, 8'h01, 8'hFF,
      // All-ones service with an empty descriptor loop.
      8'hFF, 8'hFF, 8'hFF, 8'hF0, 8'h00,
      // Zero-length descriptor followed by one with a two-byte body.
      8'h00, 8'h00, 8'hFC, 8'h00, 8'h06, 8'h48, 8'h00, 8'hFF, 8'h02, 8'hAA, 8'h55,
      // Descriptor tag is the last byte of its loop.
      8'h12, 8'h34, 8'h01, 8'h00, 8'h01, 8'h4D,
      // Descriptor body runs past the end of its loop.
      8'h00, 8'hFF, 8'h02, 8'h80, 8'h03, 8'h4A, 8'h05, 8'h11,
      // Entry head cut short by the end of the service loop.
      8'hAB, 8'hCD, 8'h03,
      8'hDE, 8'hAD, 8'hBE, 8'hEF};
    send_section();
  endtask

  // Mostly well-formed sections, some damaged, plus rejects and byte noise.
  task automatic test_random_sections();
    int unsigned goal;
    int          pick;
    int          at;
    goal = bytes_parsed + ItemTarget;
    while (bytes_parsed < goal) begin
      src_mode  = $urandom_range(0, 2);
      sink_mode = $urandom_range(0, 2);
      pick      = $urandom_range(0, 19);
      if (pick < 14) begin
        if (pick == 0) build_section(3, 3, 40);
        else build_section($urandom_range(0, 3), 3, 6);
        if ($urandom_range(0, 4) == 0) begin
          at = $urandom_range(1, section_bytes.size() - 1);
          case ($urandom_range(0, 3))
            0: while (section_bytes.size() > at) section_bytes.delete(section_bytes.size() - 1);
            1: section_bytes[at] = 8'($urandom);
            2: begin
              // Section length that disagrees with the content.
              section_bytes[1][3:0] = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'd0;
              section_bytes[2]      = 8'($urandom);
            end
            default: section_bytes.insert(at, 8'($urandom));
          endcase
        end
        send_section();
      end else if (pick < 17) begin
        section_bytes = {};
        section_bytes = {section_bytes, 8'($urandom)};
        if ($urandom_range(0, 1) == 0) begin
          section_bytes = {section_bytes, {1'b0, 7'($urandom)}};
          section_bytes = {section_bytes, 8'($urandom)};
        end else begin
          section_bytes = {section_bytes, {1'b1, 3'($urandom), 4'h0}};
          section_bytes = {section_bytes, 8'($urandom_range(0, ShortestSection - 1))};
        end
        send_section();
      end else begin
        repeat ($urandom_range(1, 8)) send_beat(8'($urandom), $urandom_range(0, 5) == 0);
      end
    end
  endtask

  // Run limit.
  initial begin : watchdog_proc
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Timed out after %0d cycles, %0d records outstanding.", cycle_count,
             expected_records.size());
    $display("Regression FAIL");
    $finish;
  end

  // Reset, test sequence and final verdict.
  initial begin
    rst_ni          <= 1'b0;
    in_valid_i      <= 1'b0;
    data_byte_i     <= 8'h00;
    section_start_i <= 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reject_and_idle();
    test_header_extremes();
    test_empty_service_loop();
    test_service_loop_cases();
    test_random_sections();
    in_valid_i <= 1'b0;

    while (expected_records.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (expected_records.size() != 0) begin
      $display("%0d expected records never arrived.", expected_records.size());
      fail_count += expected_records.size();
    end
    $display("Sent %0d section bytes (%0d parsed) in %0d cycles and checked %0d records:",
             bytes_sent, bytes_parsed, cycle_count, records_checked);
    $display("%0d header, %0d service, %0d descriptor, %0d crc, %0d reject; %0d failures.",
             kind_seen[KIND_HEADER], kind_seen[KIND_SERVICE], kind_seen[KIND_DESCRIPTOR],
             kind_seen[KIND_CRC], kind_seen[KIND_REJECT], fail_count);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/sdtp_pkg.sv
hw/rtl/sdt_section_parser_unit.sv
dv/sdt_section_parser_unit_tb.sv
